// ===== sv/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the phase polynomial tracker
// Sizes, field widths, opcodes, status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ppt_pkg;

    // sizes
    localparam int MAX_QUBITS = 16;
    localparam int MAX_GROUPS = 64;

    // derived widths
    localparam int QUBIT_W  = $clog2(MAX_QUBITS);
    localparam int FUNC_W   = MAX_QUBITS + 1;
    localparam int GRP_AW   = $clog2(MAX_GROUPS);
    localparam int USED_W   = GRP_AW + 1;
    localparam int COUNT_W  = 8;
    localparam int ENTRY_W  = COUNT_W + FUNC_W;
    localparam int ACTIVE_W = 5;
    localparam int OP_W     = 2;
    localparam int STS_W    = 2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 8'd255;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 5'd16;
    localparam logic [ACTIVE_W-1:0] ACTIVE_LIMIT  = ACTIVE_W'(MAX_QUBITS);

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_X     = 2'd1;
    localparam logic [OP_W-1:0] OP_CNOT  = 2'd2;
    localparam logic [OP_W-1:0] OP_RZ    = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD_QUBIT = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CNOT,
        S_RD,
        S_CMP,
        S_MISS,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;    // take the input beat
        logic clear;      // reset rows and group table
        logic bad;        // report a bad qubit index
        logic x_wr;       // flip constant bit of the wire
        logic row_load;   // load the first wire's row, start a scan
        logic sel_b;      // point the row port at the second wire
        logic cnot_wr;    // XOR the held control row into the target
        logic scan_next;  // step to the next group entry
        logic hit;        // bump the matched group
        logic insert;     // open a new group
        logic full;       // report a full table
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            used_zero;
        logic            table_full;
        logic            match;
        logic            last_entry;
    } t_dp_stat;

endpackage

// ===== sv/ppt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_datapath: wire rows, group table and result registers
// Holds the affine row of every wire, the group memory with its fill count,
// the mergeable flag, the active wire register and the output payload.
// ----------------------------------------------------------------------------
module ppt_datapath import ppt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [QUBIT_W-1:0]  i_first_qubit,
    input  logic [QUBIT_W-1:0]  i_second_qubit,
    input  logic                i_cfg_wr_en,
    input  logic [ACTIVE_W-1:0] i_cfg_wr_data,
    output logic [FUNC_W-1:0]   o_affine_func,
    output logic [GRP_AW-1:0]   o_group_index,
    output logic [COUNT_W-1:0]  o_group_count,
    output logic                o_any_mergeable,
    output logic [STS_W-1:0]    o_status
);

    logic [ACTIVE_W-1:0] r_active;
    logic [OP_W-1:0]     r_op;
    logic [QUBIT_W-1:0]  r_qa;
    logic [QUBIT_W-1:0]  r_qb;
    logic [FUNC_W-1:0]   r_rows [MAX_QUBITS];
    logic [ENTRY_W-1:0]  r_grp_mem [MAX_GROUPS];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [GRP_AW-1:0]   r_scan_addr;
    logic [USED_W-1:0]   r_used;
    logic                r_flag;
    logic [FUNC_W-1:0]   r_res_func;
    logic [GRP_AW-1:0]   r_res_idx;
    logic [COUNT_W-1:0]  r_res_cnt;
    logic [STS_W-1:0]    r_res_sts;
    logic [FUNC_W-1:0]   r_out_func;
    logic [GRP_AW-1:0]   r_out_idx;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic                r_out_flag;
    logic [STS_W-1:0]    r_out_sts;

    logic [ACTIVE_W-1:0] limit;
    logic                ok_a;
    logic                ok_b;
    logic [QUBIT_W-1:0]  row_sel;
    logic [FUNC_W-1:0]   row_rd;
    logic [COUNT_W-1:0]  old_count;
    logic [COUNT_W-1:0]  n_count;

    // hold the active wire count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_qa <= i_first_qubit;
            r_qb <= i_second_qubit;
        end
    end

    // check qubit indexes against the wires in use
    always_comb begin
        limit = (r_active > ACTIVE_LIMIT) ? ACTIVE_LIMIT : r_active;
        ok_a  = {1'b0, r_qa} < limit;
        ok_b  = {1'b0, r_qb} < limit;
    end

    // one row port, shared by both wires
    assign row_sel = i_cmd.sel_b ? r_qb : r_qa;
    assign row_rd  = r_rows[row_sel];

    // update wire rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_QUBITS; i++) begin
                r_rows[i] <= FUNC_W'(1) << (i + 1);
            end
        end else if (i_cmd.x_wr) begin
            r_rows[row_sel] <= row_rd ^ FUNC_W'(1);
        end else if (i_cmd.cnot_wr) begin
            r_rows[row_sel] <= row_rd ^ r_res_func;
        end
    end

    // saturating count of the entry under compare
    always_comb begin
        old_count = r_rdata[ENTRY_W-1:FUNC_W];
        n_count   = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);
    end

    // group memory: one write port, one registered read at the scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit) begin
            r_grp_mem[r_scan_addr] <= {n_count, r_res_func};
        end else if (i_cmd.insert) begin
            r_grp_mem[r_used[GRP_AW-1:0]] <= {COUNT_W'(1), r_res_func};
        end
        r_rdata <= r_grp_mem[r_scan_addr];
    end

    // advance the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan_addr <= r_scan_addr + GRP_AW'(1);
        end
    end

    // fill count and mergeable flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_used <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_used <= r_used + USED_W'(1);
            end
            if (i_cmd.hit && (n_count > COUNT_W'(1))) begin
                r_flag <= 1'b1;
            end
        end
    end

    // build the result of the current item
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.clear) begin
            r_res_func <= '0;
            r_res_idx  <= '0;
            r_res_cnt  <= '0;
            r_res_sts  <= STS_OK;
        end else if (i_cmd.bad) begin
            r_res_func <= '0;
            r_res_idx  <= '0;
            r_res_cnt  <= '0;
            r_res_sts  <= STS_BAD_QUBIT;
        end else if (i_cmd.x_wr) begin
            r_res_func <= row_rd ^ FUNC_W'(1);
            r_res_idx  <= '0;
            r_res_cnt  <= '0;
            r_res_sts  <= STS_OK;
        end else if (i_cmd.row_load) begin
            r_res_func <= row_rd;
            r_res_idx  <= '0;
            r_res_cnt  <= '0;
            r_res_sts  <= STS_OK;
        end else if (i_cmd.cnot_wr) begin
            r_res_func <= row_rd ^ r_res_func;
        end else if (i_cmd.hit) begin
            r_res_idx <= r_scan_addr;
            r_res_cnt <= n_count;
        end else if (i_cmd.insert) begin
            r_res_idx <= r_used[GRP_AW-1:0];
            r_res_cnt <= COUNT_W'(1);
        end else if (i_cmd.full) begin
            r_res_sts <= STS_FULL;
        end else begin
            r_res_sts <= r_res_sts;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_func <= r_res_func;
            r_out_idx  <= r_res_idx;
            r_out_cnt  <= r_res_cnt;
            r_out_flag <= r_flag;
            r_out_sts  <= r_res_sts;
        end
    end

    assign o_affine_func   = r_out_func;
    assign o_group_index   = r_out_idx;
    assign o_group_count   = r_out_cnt;
    assign o_any_mergeable = r_out_flag;
    assign o_status        = r_out_sts;

    // status toward the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.bad        = (r_op == OP_CNOT) ? !(ok_a && ok_b) : !ok_a;
        o_stat.used_zero  = (r_used == '0);
        o_stat.table_full = (r_used == USED_W'(MAX_GROUPS));
        o_stat.match      = (r_rdata[FUNC_W-1:0] == r_res_func);
        o_stat.last_entry = (({1'b0, r_scan_addr} + USED_W'(1)) == r_used);
    end

endmodule

// ===== sv/ppt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ctrl: sequencer of the phase polynomial tracker
// Takes one beat at a time, steps the datapath through the operation and
// the group scan, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ppt_ctrl import ppt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   out_free;

    assign out_free = !r_out_vld || !i_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                priority if (i_stat.op == OP_CLEAR) n_state = S_DONE;
                else if (i_stat.bad)                n_state = S_DONE;
                else if (i_stat.op == OP_X)         n_state = S_DONE;
                else if (i_stat.op == OP_CNOT)      n_state = S_CNOT;
                else if (i_stat.used_zero)          n_state = S_MISS;
                else                                n_state = S_RD;
            end
            S_CNOT: n_state = S_DONE;
            S_RD:   n_state = S_CMP;
            S_CMP: begin
                priority if (i_stat.match)     n_state = S_DONE;
                else if (i_stat.last_entry)    n_state = S_MISS;
                else                           n_state = S_RD;
            end
            S_MISS: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_valid;
            S_EXEC: begin
                priority if (i_stat.op == OP_CLEAR) o_cmd.clear = 1'b1;
                else if (i_stat.bad)                o_cmd.bad = 1'b1;
                else if (i_stat.op == OP_X)         o_cmd.x_wr = 1'b1;
                else                                o_cmd.row_load = 1'b1;
            end
            S_CNOT: begin
                o_cmd.sel_b   = 1'b1;
                o_cmd.cnot_wr = 1'b1;
            end
            S_RD: o_cmd = '0;
            S_CMP: begin
                o_cmd.hit       = i_stat.match;
                o_cmd.scan_next = !i_stat.match && !i_stat.last_entry;
            end
            S_MISS: begin
                // a fill count at the top means no free entry
                if (i_stat.table_full) begin
                    o_cmd.full = 1'b1;
                end else begin
                    o_cmd.insert = 1'b1;
                end
            end
            S_DONE: o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    // output valid: set on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== sv/phase_polynomial_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_polynomial_tracker_top: parity tracking of a phase polynomial
// Tracks one affine parity row per qubit wire and files Rz gates in a
// content-matched group table; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat gives exactly one result beat. A clear, an X gate or a bad
// qubit index goes from accept through execute and done back to idle; a CNOT
// also passes a CNOT step, since the single row port reads control and target
// in turn. An Rz gate scans the group memory entry by entry (read, then
// compare of the registered word) up to the match; a new function then takes
// a miss step that opens a group or reports a full table. The next beat is
// taken while an earlier result still waits in the output register; the
// block holds in its last step only when that register is still occupied
// and the receiver stalls. Clear empties the table at once by resetting the
// fill count, so there is no clearing pass after reset.
module phase_polynomial_tracker_top import ppt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [QUBIT_W-1:0]  i_first_qubit,
    input  logic [QUBIT_W-1:0]  i_second_qubit,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [FUNC_W-1:0]   o_affine_func,
    output logic [GRP_AW-1:0]   o_group_index,
    output logic [COUNT_W-1:0]  o_group_count,
    output logic                o_any_mergeable,
    output logic [STS_W-1:0]    o_status,
    input  logic                i_cfg_wr_en,
    input  logic [ACTIVE_W-1:0] i_cfg_wr_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ppt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    ppt_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_op            (i_op),
        .i_first_qubit   (i_first_qubit),
        .i_second_qubit  (i_second_qubit),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_affine_func   (o_affine_func),
        .o_group_index   (o_group_index),
        .o_group_count   (o_group_count),
        .o_any_mergeable (o_any_mergeable),
        .o_status        (o_status)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the phase polynomial tracker
// Drives gate beats (clear, X, CNOT, Rz) through the valid/stall port and
// predicts every result with a behavioral copy of the parity rows and the
// group table. Each output beat is compared field by field with the oldest
// prediction. Directed cases come first, then long random gate streams
// under several wire counts and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import ppt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [GRP_AW-1:0]  gidx;
        logic [COUNT_W-1:0] gcount;
        logic               merge;
        logic [STS_W-1:0]   sts;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_op = OP_CLEAR;
    logic [QUBIT_W-1:0]  i_first_qubit = '0;
    logic [QUBIT_W-1:0]  i_second_qubit = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [FUNC_W-1:0]   o_affine_func;
    logic [GRP_AW-1:0]   o_group_index;
    logic [COUNT_W-1:0]  o_group_count;
    logic                o_any_mergeable;
    logic [STS_W-1:0]    o_status;
    logic                i_cfg_wr_en = 1'b0;
    logic [ACTIVE_W-1:0] i_cfg_wr_data = '0;

    // behavioral copy of the tracker state
    logic [FUNC_W-1:0]   wire_row_copy[MAX_QUBITS];
    logic [FUNC_W-1:0]   group_func_copy[MAX_GROUPS];
    int                  group_count_copy[MAX_GROUPS];
    int                  groups_open;
    logic                merge_seen;
    logic [ACTIVE_W-1:0] wires_in_use;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;

    phase_polynomial_tracker_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_first_qubit   (i_first_qubit),
        .i_second_qubit  (i_second_qubit),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_affine_func   (o_affine_func),
        .o_group_index   (o_group_index),
        .o_group_count   (o_group_count),
        .o_any_mergeable (o_any_mergeable),
        .o_status        (o_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // reset rows to identity and empty the group table
    function automatic void clear_tracking();
        for (int q = 0; q < MAX_QUBITS; q++) begin
            wire_row_copy[q] = '0;
            wire_row_copy[q][q+1] = 1'b1;
        end
        for (int g = 0; g < MAX_GROUPS; g++) begin
            group_func_copy[g] = '0;
            group_count_copy[g] = 0;
        end
        groups_open = 0;
        merge_seen = 1'b0;
    endfunction

    // apply one gate to the state copy and return the result it must give
    function automatic t_result track_gate(input logic [OP_W-1:0] op,
                                           input logic [QUBIT_W-1:0] qa,
                                           input logic [QUBIT_W-1:0] qb);
        t_result r;
        int      lim;
        int      hit;
        r = '0;
        hit = -1;
        lim = (wires_in_use < MAX_QUBITS) ? int'(wires_in_use) : MAX_QUBITS;
        case (op)
            OP_CLEAR: begin
                clear_tracking();
            end
            OP_X: begin
                if (int'(qa) < lim) begin
                    wire_row_copy[qa][0] = ~wire_row_copy[qa][0];
                    r.func = wire_row_copy[qa];
                end else begin
                    r.sts = STS_BAD_QUBIT;
                end
            end
            OP_CNOT: begin
                if (int'(qa) < lim && int'(qb) < lim) begin
                    wire_row_copy[qb] = wire_row_copy[qb] ^ wire_row_copy[qa];
                    r.func = wire_row_copy[qb];
                end else begin
                    r.sts = STS_BAD_QUBIT;
                end
            end
            default: begin
                if (int'(qa) >= lim) begin
                    r.sts = STS_BAD_QUBIT;
                end else begin
                    r.func = wire_row_copy[qa];
                    for (int g = 0; g < groups_open; g++) begin
                        if (hit < 0 && group_func_copy[g] == r.func) hit = g;
                    end
                    if (hit < 0) begin
                        if (groups_open >= MAX_GROUPS) begin
                            r.sts = STS_FULL;
                        end else begin
                            hit = groups_open;
                            group_func_copy[hit] = r.func;
                            group_count_copy[hit] = 0;
                            groups_open++;
                        end
                    end
                    if (hit >= 0) begin
                        if (group_count_copy[hit] < int'(COUNT_MAX))
                            group_count_copy[hit]++;
                        if (group_count_copy[hit] > 1) merge_seen = 1'b1;
                        r.gidx = GRP_AW'(hit);
                        r.gcount = COUNT_W'(group_count_copy[hit]);
                    end
                end
            end
        endcase
        r.merge = merge_seen;
        return r;
    endfunction

    // send one gate beat, predict its result once it is taken
    task automatic send_gate(input logic [OP_W-1:0] op,
                             input logic [QUBIT_W-1:0] qa,
                             input logic [QUBIT_W-1:0] qb);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_op <= op;
        i_first_qubit <= qa;
        i_second_qubit <= qb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(track_gate(op, qa, qb));
    endtask

    // drop valid and hold until every predicted beat has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // write the wire count while the block is idle
    task automatic set_wires(input logic [ACTIVE_W-1:0] value);
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= ACTIVE_W'($urandom());
        wires_in_use = value;
    endtask

    // pick a wire, mostly a legal one
    function automatic logic [QUBIT_W-1:0] pick_wire();
        int lim;
        lim = (wires_in_use < MAX_QUBITS) ? int'(wires_in_use) : MAX_QUBITS;
        if (lim == 0 || $urandom_range(0, 99) < 12) return QUBIT_W'($urandom());
        return QUBIT_W'($urandom_range(0, lim - 1));
    endfunction

    // every op, row extremes, self CNOT and a mergeable pair
    task automatic test_basic_ops();
        idle_pct = 0;
        stall_pct = 0;
        send_gate(OP_RZ, 4'd0, 4'd15);
        send_gate(OP_RZ, 4'd15, 4'd0);
        send_gate(OP_X, 4'd0, 4'hf);
        send_gate(OP_X, 4'd15, 4'h0);
        send_gate(OP_RZ, 4'd0, 4'd0);
        send_gate(OP_CNOT, 4'd0, 4'd15);
        send_gate(OP_CNOT, 4'd15, 4'd0);
        send_gate(OP_CNOT, 4'd3, 4'd3);
        send_gate(OP_RZ, 4'd3, 4'd9);
        send_gate(OP_RZ, 4'd5, 4'd0);
        send_gate(OP_RZ, 4'd5, 4'd15);
        send_gate(OP_CLEAR, 4'd15, 4'd15);
        send_gate(OP_RZ, 4'd5, 4'd0);
        send_gate(OP_X, 4'd10, 4'd5);
    endtask

    // out of range wires under small, zero and oversized wire counts
    task automatic test_bad_index();
        set_wires(5'd4);
        send_gate(OP_X, 4'd4, 4'd0);
        send_gate(OP_CNOT, 4'd0, 4'd9);
        send_gate(OP_CNOT, 4'd9, 4'd0);
        send_gate(OP_RZ, 4'd15, 4'd0);
        send_gate(OP_X, 4'd3, 4'd0);
        set_wires(5'd0);
        send_gate(OP_X, 4'd0, 4'd0);
        send_gate(OP_RZ, 4'd0, 4'd0);
        send_gate(OP_CLEAR, 4'd0, 4'd0);
        set_wires(5'd31);
        send_gate(OP_RZ, 4'd15, 4'd0);
        send_gate(OP_CNOT, 4'd15, 4'd14);
        set_wires(5'd1);
        send_gate(OP_RZ, 4'd0, 4'd0);
        send_gate(OP_X, 4'd1, 4'd0);
        set_wires(5'd16);
    endtask

    // fill the group table, then offer new and known functions
    task automatic test_table_full();
        logic [QUBIT_W-1:0] qa;
        logic [QUBIT_W-1:0] qb;
        send_gate(OP_CLEAR, 4'd0, 4'd0);
        for (int i = 0; i < 400 && groups_open < MAX_GROUPS; i++) begin
            qa = QUBIT_W'($urandom());
            qb = QUBIT_W'($urandom());
            if (qa == qb) qb = qa + 1'b1;
            send_gate(OP_CNOT, qa, qb);
            send_gate(OP_RZ, qb, qa);
        end
        repeat (4) begin
            qa = QUBIT_W'($urandom());
            send_gate(OP_X, qa, 4'd0);
            send_gate(OP_RZ, qa, 4'd0);
            send_gate(OP_CNOT, qa, qa + 1'b1);
            send_gate(OP_RZ, qa + 1'b1, 4'd0);
        end
        send_gate(OP_CLEAR, 4'd0, 4'd0);
    endtask

    // hammer one function until its count saturates
    task automatic test_count_saturation();
        send_gate(OP_CLEAR, 4'd0, 4'd0);
        send_gate(OP_X, 4'd7, 4'd0);
        repeat (int'(COUNT_MAX) + 3) send_gate(OP_RZ, 4'd7, QUBIT_W'($urandom()));
    endtask

    // random gate stream: mostly legal wires, occasional clear and noise
    task automatic test_random_gates(input int beats, input int idle,
                                     input int stall, input bit pause_mid);
        int                 roll;
        logic [QUBIT_W-1:0] qa;
        logic [QUBIT_W-1:0] qb;
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < beats; n++) begin
            if (pause_mid && n == beats / 2) drain_results();
            roll = $urandom_range(0, 99);
            qa = pick_wire();
            qb = pick_wire();
            if (roll < 2) begin
                send_gate(OP_CLEAR, QUBIT_W'($urandom()), QUBIT_W'($urandom()));
            end else if (roll < 22) begin
                send_gate(OP_X, qa, QUBIT_W'($urandom()));
            end else if (roll < 60) begin
                if ($urandom_range(0, 99) < 5) qb = qa;
                send_gate(OP_CNOT, qa, qb);
            end else begin
                send_gate(OP_RZ, qa, QUBIT_W'($urandom()));
            end
        end
    endtask

    // random receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_affine_func, o_group_index, o_group_count,
                   o_any_mergeable, o_status};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: func=%h idx=%0d cnt=%0d merge=%0b sts=%0d",
                             got.func, got.gidx, got.gcount, got.merge, got.sts);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch exp: func=%h idx=%0d cnt=%0d merge=%0b sts=%0d",
                                 want.func, want.gidx, want.gcount, want.merge, want.sts);
                        $display("         act: func=%h idx=%0d cnt=%0d merge=%0b sts=%0d",
                                 got.func, got.gidx, got.gcount, got.merge, got.sts);
                    end
                end
            end
        end
    end

    // end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        wires_in_use = ACTIVE_RESET;
        clear_tracking();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_basic_ops();
        test_bad_index();
        test_table_full();
        test_count_saturation();

        test_random_gates(330, 0, 0, 1'b0);
        set_wires(5'($urandom_range(2, 15)));
        test_random_gates(330, 68, 0, 1'b0);
        set_wires(5'd16);
        test_random_gates(330, 0, 68, 1'b1);
        set_wires(5'd31);
        test_random_gates(330, 11, 11, 1'b0);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
